/* sv/multi_channel_byte_ring_table_unit_assert.svh */
// Assertion macros for the channel ring table checker.
`ifndef MULTI_CHANNEL_BYTE_RING_TABLE_UNIT_ASSERT_SVH
`define MULTI_CHANNEL_BYTE_RING_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MCBRT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MCBRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/mcbrt_pkg.sv */
package mcbrt_pkg;

    localparam logic [2:0] OP_ALLOC   = 3'd0;
    localparam logic [2:0] OP_RETAIN  = 3'd1;
    localparam logic [2:0] OP_RELEASE = 3'd2;
    localparam logic [2:0] OP_WRITE   = 3'd3;
    localparam logic [2:0] OP_READ    = 3'd4;

    localparam logic [2:0] CMD_ALLOC   = 3'd0;
    localparam logic [2:0] CMD_RETAIN  = 3'd1;
    localparam logic [2:0] CMD_RELEASE = 3'd2;
    localparam logic [2:0] CMD_WRITE   = 3'd3;
    localparam logic [2:0] CMD_READ    = 3'd4;
    localparam logic [2:0] CMD_NOP     = 3'd5;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_UNKNOWN = 3'd1;
    localparam logic [2:0] ST_NOSLOT  = 3'd2;
    localparam logic [2:0] ST_EMPTY   = 3'd3;
    localparam logic [2:0] ST_REFLIM  = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] chan_id;
        logic [7:0]  data;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] new_id;
        logic [7:0]  data_out;
    } t_rsp;

endpackage

/* sv/mcbrt_if.sv */
interface mcbrt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [31:0] chan_id;
    logic [7:0]  data_in;

    modport source (output valid, op, chan_id, data_in, input ready);
    modport sink (input valid, op, chan_id, data_in, output ready);
endinterface

interface mcbrt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] new_id;
    logic [7:0]  data_out;

    modport source (output valid, status, new_id, data_out, input ready);
    modport sink (input valid, status, new_id, data_out, output ready);
endinterface

/* sv/mcbrt_ram.sv */
module mcbrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/mcbrt_front.sv */
module mcbrt_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mcbrt_req_if.sink          i_req,
    output logic               o_cmd_valid,
    output mcbrt_pkg::t_cmd    o_cmd,
    input  logic               i_cmd_pop
);
    import mcbrt_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;
    t_cmd       cls;

    always_comb begin
        cls.chan_id = i_req.chan_id;
        cls.data    = i_req.data_in;
        unique case (i_req.op)
            OP_ALLOC:   cls.kind = CMD_ALLOC;
            OP_RETAIN:  cls.kind = CMD_RETAIN;
            OP_RELEASE: cls.kind = CMD_RELEASE;
            OP_WRITE:   cls.kind = CMD_WRITE;
            OP_READ:    cls.kind = CMD_READ;
            default:    cls.kind = CMD_NOP;
        endcase
    end

    assign i_req.ready = (r_cnt != 2'd2);
    assign push        = i_req.valid && i_req.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_cmd_pop);
        end
    end
endmodule

/* sv/mcbrt_back.sv */
module mcbrt_back #(
    parameter int SLOT_COUNT = 16,
    parameter int RING_DEPTH = 8192,
    parameter int REF_BITS   = 16,
    parameter int ID_BITS    = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  mcbrt_pkg::t_cmd    i_cmd,
    output logic               o_cmd_pop,
    mcbrt_rsp_if.source        o_rsp
);
    import mcbrt_pkg::*;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int MEM_D  = SLOT_COUNT * RING_DEPTH;
    localparam int ADDR_W = $clog2(MEM_D);
    localparam int CMP_W  = (ID_BITS > 32) ? ID_BITS : 32;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_RDATA = 2'd2;

    logic                r_used  [SLOT_COUNT];
    logic [ID_BITS-1:0]  r_ident [SLOT_COUNT];
    logic [REF_BITS-1:0] r_ref   [SLOT_COUNT];
    logic [PTR_W-1:0]    r_head  [SLOT_COUNT];
    logic [PTR_W-1:0]    r_tail  [SLOT_COUNT];
    logic [FILL_W-1:0]   r_fill  [SLOT_COUNT];
    logic [ID_BITS-1:0]  r_id_ctr, n_id_ctr;

    logic [1:0]        r_state;
    t_cmd              r_cmd;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_hit, n_hit;
    t_rsp              r_out;
    logic              r_out_valid;

    logic              out_free;
    logic [CMP_W-1:0]  ctr_ext;
    logic [ADDR_W-1:0] base;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_rdata;
    logic [2:0]        ex_status;

    function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign out_free  = !r_out_valid || o_rsp.ready;
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    assign ctr_ext   = CMP_W'(r_id_ctr);
    assign base      = ADDR_W'(r_slot) * ADDR_W'(RING_DEPTH);
    assign ram_waddr = base + ADDR_W'(r_head[r_slot]);
    assign ram_raddr = base + ADDR_W'(r_tail[r_slot]);

    always_comb begin
        n_hit  = 1'b0;
        n_slot = '0;
        if (i_cmd.kind == CMD_ALLOC) begin
            for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
                if (!r_used[i]) begin
                    n_hit  = 1'b1;
                    n_slot = SLOT_W'(i);
                end
            end
        end else begin
            for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
                if (r_used[i] && i_cmd.chan_id != 32'd0
                        && CMP_W'(r_ident[i]) == CMP_W'(i_cmd.chan_id)) begin
                    n_hit  = 1'b1;
                    n_slot = SLOT_W'(i);
                end
            end
        end
        n_id_ctr = r_id_ctr + ID_BITS'(1);
        if (n_id_ctr == '0) begin
            n_id_ctr = ID_BITS'(1);
        end
    end

    always_comb begin
        ex_status = ST_OK;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        if (r_state == S_EXEC && out_free) begin
            case (r_cmd.kind)
                CMD_ALLOC: begin
                    if (!r_hit) ex_status = ST_NOSLOT;
                end
                CMD_RETAIN: begin
                    if (!r_hit) ex_status = ST_UNKNOWN;
                    else if (r_ref[r_slot] == {REF_BITS{1'b1}}) ex_status = ST_REFLIM;
                end
                CMD_RELEASE: begin
                    if (!r_hit) ex_status = ST_UNKNOWN;
                end
                CMD_WRITE: begin
                    if (!r_hit) ex_status = ST_UNKNOWN;
                    else ram_we = 1'b1;
                end
                CMD_READ: begin
                    if (!r_hit) ex_status = ST_UNKNOWN;
                    else if (r_fill[r_slot] == '0) ex_status = ST_EMPTY;
                    else ram_re = 1'b1;
                end
                default: ex_status = ST_OK;
            endcase
        end
    end

    mcbrt_ram #(.WIDTH(8), .DEPTH(MEM_D)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_cmd.data),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd  <= i_cmd;
            r_slot <= n_slot;
            r_hit  <= n_hit;
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_id_ctr    <= ID_BITS'(1);
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_used[i]  <= 1'b0;
                r_ident[i] <= '0;
                r_ref[i]   <= '0;
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_fill[i]  <= '0;
            end
        end else begin
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (out_free) begin
                        r_out.status   <= ex_status;
                        r_out.new_id   <= '0;
                        r_out.data_out <= '0;
                        if (ram_re) begin
                            r_state <= S_RDATA;
                        end else begin
                            r_state     <= S_IDLE;
                            r_out_valid <= 1'b1;
                        end
                        if (r_hit) begin
                            case (r_cmd.kind)
                                CMD_ALLOC: begin
                                    r_out.new_id    <= ctr_ext[31:0];
                                    r_id_ctr        <= n_id_ctr;
                                    r_used[r_slot]  <= 1'b1;
                                    r_ident[r_slot] <= r_id_ctr;
                                    r_ref[r_slot]   <= REF_BITS'(1);
                                    r_head[r_slot]  <= '0;
                                    r_tail[r_slot]  <= '0;
                                    r_fill[r_slot]  <= '0;
                                end
                                CMD_RETAIN: begin
                                    if (ex_status == ST_OK) begin
                                        r_ref[r_slot] <= r_ref[r_slot] + REF_BITS'(1);
                                    end
                                end
                                CMD_RELEASE: begin
                                    if (r_ref[r_slot] > REF_BITS'(1)) begin
                                        r_ref[r_slot] <= r_ref[r_slot] - REF_BITS'(1);
                                    end else begin
                                        r_used[r_slot]  <= 1'b0;
                                        r_ident[r_slot] <= '0;
                                        r_ref[r_slot]   <= '0;
                                        r_head[r_slot]  <= '0;
                                        r_tail[r_slot]  <= '0;
                                        r_fill[r_slot]  <= '0;
                                    end
                                end
                                CMD_WRITE: begin
                                    r_head[r_slot] <= next_pos(r_head[r_slot]);
                                    if (r_fill[r_slot] == FILL_W'(RING_DEPTH)) begin
                                        r_tail[r_slot] <= next_pos(r_tail[r_slot]);
                                    end else begin
                                        r_fill[r_slot] <= r_fill[r_slot] + FILL_W'(1);
                                    end
                                end
                                CMD_READ: begin
                                    if (ram_re) begin
                                        r_tail[r_slot] <= next_pos(r_tail[r_slot]);
                                        r_fill[r_slot] <= r_fill[r_slot] - FILL_W'(1);
                                    end
                                end
                                default: r_state <= S_IDLE;
                            endcase
                        end
                    end
                end
                S_RDATA: begin
                    if (out_free) begin
                        r_out.data_out <= ram_rdata;
                        r_out_valid    <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_out.status;
    assign o_rsp.new_id   = r_out.new_id;
    assign o_rsp.data_out = r_out.data_out;
endmodule

/* sv/multi_channel_byte_ring_table_unit.sv */
// Flow: requests wait in the front queue; the back end registers the slot lookup
// in S_IDLE and the response in S_EXEC (read_byte adds S_RDATA for the registered
// ring memory read), and pops no new command until the response is registered.
// Reset: synchronous, active low; empties the slot table and request queue,
// sets the id counter to 1. Ring memory contents are not cleared.
module multi_channel_byte_ring_table_unit #(
    parameter int SLOT_COUNT = 16,
    parameter int RING_DEPTH = 8192,
    parameter int REF_BITS   = 16,
    parameter int ID_BITS    = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mcbrt_req_if.sink   i_req,
    mcbrt_rsp_if.source o_rsp
);
    import mcbrt_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;

    mcbrt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    mcbrt_back #(
        .SLOT_COUNT (SLOT_COUNT),
        .RING_DEPTH (RING_DEPTH),
        .REF_BITS   (REF_BITS),
        .ID_BITS    (ID_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_rsp       (o_rsp)
    );
endmodule

/* sv/mcbrt_checker.sv */
`include "multi_channel_byte_ring_table_unit_assert.svh"

module mcbrt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [2:0]  i_status,
    input logic [31:0] i_new_id,
    input logic [7:0]  i_data_out
);
    import mcbrt_pkg::*;

    `MCBRT_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_status) && $stable(i_new_id) && $stable(i_data_out), "response dropped or changed while stalled")
    `MCBRT_ASSERT_NOW(a_err_clean, i_clk, i_rst_n, i_rsp_valid && i_status != ST_OK, i_new_id == 32'd0 && i_data_out == 8'd0, "error response carries payload")
    `MCBRT_ASSERT_NOW(a_id_ok, i_clk, i_rst_n, i_rsp_valid && i_new_id != 32'd0, i_status == ST_OK && i_data_out == 8'd0, "new id on non-alloc response")
    `MCBRT_ASSERT_NOW(a_status_code, i_clk, i_rst_n, i_rsp_valid, i_status == ST_OK || i_status == ST_UNKNOWN || i_status == ST_NOSLOT || i_status == ST_EMPTY || i_status == ST_REFLIM, "undefined status")
endmodule

bind multi_channel_byte_ring_table_unit mcbrt_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_new_id    (o_rsp.new_id),
    .i_data_out  (o_rsp.data_out)
);
